### rtl/core/spi_register_frame_crc8_macros.svh
// assertion helpers for the frame builder, clocked on clk and held off in reset
`ifndef SPI_REGISTER_FRAME_CRC8_MACROS_SVH
`define SPI_REGISTER_FRAME_CRC8_MACROS_SVH

// same-cycle implication
`define SRFC8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRFC8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/srfc8_pkg.sv
package srfc8_pkg;

  // request type codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result kind codes
  localparam logic OUT_FRAME  = 1'b0;
  localparam logic OUT_RESULT = 1'b1;

  // frame constants
  localparam logic [8:0] CRC_POLY = 9'h107;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] READ_BIT = 8'h01;
  localparam logic [7:0] FILLER   = 8'hFF;
  localparam int         BASE_LEN = 4;
  localparam int         IDX_W    = $clog2(BASE_LEN + 1);

  // input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] data_low;
    logic [7:0] data_high;
    logic [7:0] rx_crc;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] read_data;
    logic        crc_error;
    logic        last;
  } out_item_t;

  // item inside the pipeline: the four base bytes and the running crc
  typedef struct packed {
    logic [1:0]                 req_type;
    logic [BASE_LEN-1:0][7:0]   bytes;
    logic [7:0]                 rx_crc;
    logic [7:0]                 crc;
  } frame_t;

  typedef logic [7:0] crc_tab_t [256];

  // byte-wise crc-8 table, built at elaboration
  function automatic crc_tab_t crc_tab_build();
    crc_tab_t   tab;
    logic [7:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 8'(i);
      for (int j = 0; j < 8; j++) begin
        if ((c & CRC_TOP) != 8'h00) begin
          c = (c << 1) ^ CRC_POLY[7:0];
        end else begin
          c = c << 1;
        end
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TAB = crc_tab_build();

endpackage

### rtl/core/srfc8_prep.sv
module srfc8_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srfc8_pkg::in_item_t  in_item,
  output logic                 q_valid,
  output srfc8_pkg::frame_t    q,
  input  logic                 dn_stall
);
  import srfc8_pkg::*;

  logic [7:0] pending_addr_byte;
  logic [7:0] pending_register;
  logic [7:0] addr_byte;
  logic       accept;
  frame_t     frame;

  assign in_stall = q_valid && dn_stall;
  assign accept   = in_valid && !in_stall;
  assign addr_byte = {in_item.device_address, 1'b0};

  // assemble the four base bytes of the item
  always_comb begin
    frame.req_type = in_item.req_type;
    frame.rx_crc   = in_item.rx_crc;
    frame.crc      = 8'h00;
    case (in_item.req_type)
      REQ_WRITE: begin
        frame.bytes = {in_item.data_high, in_item.data_low, in_item.register_index, addr_byte};
      end
      REQ_READ: begin
        frame.bytes = {FILLER, FILLER, in_item.register_index, addr_byte | READ_BIT};
      end
      default: begin
        frame.bytes = {in_item.data_high, in_item.data_low, pending_register,
                       pending_addr_byte};
      end
    endcase
  end

  // input register, unused request type is dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid && (in_item.req_type != REQ_NONE);
    end
    if (!in_stall) begin
      q <= frame;
    end
  end

  // address byte and register of the latest read request
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_addr_byte <= 8'h00;
      pending_register  <= 8'h00;
    end else if (accept && in_item.req_type == REQ_READ) begin
      pending_addr_byte <= addr_byte | READ_BIT;
      pending_register  <= in_item.register_index;
    end
  end

endmodule

### rtl/core/srfc8_fold.sv
module srfc8_fold (
  input  logic               clk,
  input  logic               rst,
  input  logic               hi_half,
  input  logic               in_valid,
  output logic               in_stall,
  input  srfc8_pkg::frame_t  in_item,
  output logic               q_valid,
  output srfc8_pkg::frame_t  q,
  input  logic               dn_stall
);
  import srfc8_pkg::*;

  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] crc_mid;
  frame_t     folded;

  assign in_stall = q_valid && dn_stall;

  // fold two bytes into the running crc
  always_comb begin
    first_byte  = hi_half ? in_item.bytes[2] : in_item.bytes[0];
    second_byte = hi_half ? in_item.bytes[3] : in_item.bytes[1];
    crc_mid     = CRC_TAB[in_item.crc ^ first_byte];
    folded      = in_item;
    folded.crc  = CRC_TAB[crc_mid ^ second_byte];
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (!in_stall) begin
      q <= folded;
    end
  end

endmodule

### rtl/core/srfc8_emit.sv
module srfc8_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  crc_enable,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  srfc8_pkg::frame_t     in_item,
  output logic                  out_valid,
  output srfc8_pkg::out_item_t  out_item,
  input  logic                  out_stall
);
  import srfc8_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic             advance;
  logic             at_last;
  logic [7:0]       tail_byte;
  out_item_t        result;

  assign advance = !out_valid || !out_stall;

  // index of the final item of this input
  always_comb begin
    if (in_item.req_type == REQ_RESP) begin
      last_idx = '0;
    end else if (crc_enable) begin
      last_idx = IDX_W'(BASE_LEN);
    end else begin
      last_idx = IDX_W'(BASE_LEN - 1);
    end
  end

  assign at_last  = (idx == last_idx);
  assign in_stall = in_valid && !(advance && at_last);

  // result item for the current index
  always_comb begin
    tail_byte = (in_item.req_type == REQ_WRITE) ? in_item.crc : FILLER;
    result    = '0;
    result.last = at_last;
    if (in_item.req_type == REQ_RESP) begin
      result.out_kind  = OUT_RESULT;
      result.read_data = {in_item.bytes[3], in_item.bytes[2]};
      result.crc_error = crc_enable && (in_item.crc != in_item.rx_crc);
    end else begin
      result.out_kind = OUT_FRAME;
      if (idx < IDX_W'(BASE_LEN)) begin
        result.tx_byte = in_item.bytes[idx[1:0]];
      end else begin
        result.tx_byte = tail_byte;
      end
    end
  end

  // byte counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
    if (advance && in_valid) begin
      out_item <= result;
    end
  end

endmodule

### rtl/core/spi_register_frame_crc8.sv
// a request passes the input register, the two crc fold stages and the output register
// a request gives 5 frame bytes with crc on and 4 with it off, one frame byte
// per cycle through the output register while res_stall is low; a read response gives one result item
// reset: clears all stage valids, the stored read address byte and register,
// and sets crc_enable to 1
`include "spi_register_frame_crc8_macros.svh"

module spi_register_frame_crc8 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  srfc8_pkg::in_item_t   req_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output srfc8_pkg::out_item_t  res_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);
  import srfc8_pkg::*;

  logic   crc_enable;
  logic   prep_valid;
  logic   prep_stall;
  frame_t prep_item;
  logic   lo_valid;
  logic   lo_stall;
  frame_t lo_item;
  logic   hi_valid;
  logic   hi_stall;
  frame_t hi_item;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      crc_enable <= cfg_data;
    end
  end

  // input register and frame assembly
  srfc8_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_stall (req_stall),
    .in_item  (req_item),
    .q_valid  (prep_valid),
    .q        (prep_item),
    .dn_stall (prep_stall)
  );

  // crc over the address and register bytes
  srfc8_fold u_fold_lo (
    .clk      (clk),
    .rst      (rst),
    .hi_half  (1'b0),
    .in_valid (prep_valid),
    .in_stall (prep_stall),
    .in_item  (prep_item),
    .q_valid  (lo_valid),
    .q        (lo_item),
    .dn_stall (lo_stall)
  );

  // crc over the two data bytes
  srfc8_fold u_fold_hi (
    .clk      (clk),
    .rst      (rst),
    .hi_half  (1'b1),
    .in_valid (lo_valid),
    .in_stall (lo_stall),
    .in_item  (lo_item),
    .q_valid  (hi_valid),
    .q        (hi_item),
    .dn_stall (hi_stall)
  );

  // byte sequencing and result register
  srfc8_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .crc_enable (crc_enable),
    .in_valid   (hi_valid),
    .in_stall   (hi_stall),
    .in_item    (hi_item),
    .out_valid  (res_valid),
    .out_item   (res_item),
    .out_stall  (res_stall)
  );

  // checks
  `SRFC8_ASSERT_NOW(a_err_needs_crc, res_valid && res_item.crc_error, crc_enable, "crc error with crc disabled")
  `SRFC8_ASSERT_NOW(a_frame_clean, res_valid && res_item.out_kind == OUT_FRAME, res_item.read_data == 16'h0000 && !res_item.crc_error, "frame byte carries read fields")
  `SRFC8_ASSERT_NOW(a_result_last, res_valid && res_item.out_kind == OUT_RESULT, res_item.last && res_item.tx_byte == 8'h00, "read result not single")
  `SRFC8_ASSERT_NEXT(a_hi_hold, hi_valid && hi_stall, hi_valid && $stable(hi_item), "item in sequencer lost")

endmodule

### tb/spi_register_frame_crc8_checker.sv
`timescale 1ns / 100ps

package srfc8_tb_pkg;
  import srfc8_pkg::*;

  // crc-8 over the four base bytes of a frame, first byte first, bit by bit
  function automatic logic [7:0] crc8_of4(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3);
    logic [BASE_LEN-1:0][7:0] seq;
    logic [7:0]               c;
    seq = {b3, b2, b1, b0};
    c = 8'h00;
    for (int i = 0; i < BASE_LEN; i++) begin
      c = c ^ seq[i];
      for (int j = 0; j < 8; j++) begin
        if ((c & CRC_TOP) != 8'h00) begin
          c = (c << 1) ^ CRC_POLY[7:0];
        end else begin
          c = c << 1;
        end
      end
    end
    return c;
  endfunction

endpackage

module spi_register_frame_crc8_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  srfc8_pkg::in_item_t   req_item,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  srfc8_pkg::out_item_t  res_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_data,
  output int                    fail_count,
  output int                    open_results
);
  import srfc8_pkg::*;
  import srfc8_tb_pkg::*;

  logic       crc_on;
  logic [7:0] rd_addr_byte;
  logic [7:0] rd_register;
  out_item_t  frame_q[$];

  // frame bytes or read result that one accepted item should produce
  task automatic predict_frames(input in_item_t it);
    logic [7:0] frame [BASE_LEN+1];
    out_item_t  o;
    int         n;
    case (it.req_type)
      REQ_WRITE, REQ_READ: begin
        if (it.req_type == REQ_WRITE) begin
          frame[0] = {it.device_address, 1'b0};
          frame[2] = it.data_low;
          frame[3] = it.data_high;
        end else begin
          frame[0] = {it.device_address, 1'b0} | READ_BIT;
          frame[2] = FILLER;
          frame[3] = FILLER;
          rd_addr_byte = frame[0];
          rd_register = it.register_index;
        end
        frame[1] = it.register_index;
        n = BASE_LEN;
        // crc byte on writes, one more filler on reads
        if (crc_on) begin
          if (it.req_type == REQ_WRITE) begin
            frame[BASE_LEN] = crc8_of4(frame[0], frame[1], frame[2], frame[3]);
          end else begin
            frame[BASE_LEN] = FILLER;
          end
          n = BASE_LEN + 1;
        end
        for (int k = 0; k < n; k++) begin
          o = '0;
          o.out_kind = OUT_FRAME;
          o.tx_byte = frame[k];
          o.last = (k == n - 1);
          frame_q.push_back(o);
        end
      end
      REQ_RESP: begin
        o = '0;
        o.out_kind = OUT_RESULT;
        o.read_data = {it.data_high, it.data_low};
        o.crc_error = crc_on &&
            (crc8_of4(rd_addr_byte, rd_register, it.data_low, it.data_high) != it.rx_crc);
        o.last = 1'b1;
        frame_q.push_back(o);
      end
      default: begin
        // unused request type is dropped without a trace
      end
    endcase
  endtask

  // compare one accepted result item with the oldest expected one
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: unexpected item kind %0d tx %02h data %04h err %0d last %0d",
                 $realtime, got.out_kind, got.tx_byte, got.read_data, got.crc_error,
                 got.last);
      end
    end else begin
      want = frame_q.pop_front();
      if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
          got.read_data !== want.read_data || got.crc_error !== want.crc_error ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch expected kind %0d tx %02h data %04h err %0d last %0d",
                   $realtime, want.out_kind, want.tx_byte, want.read_data,
                   want.crc_error, want.last);
          $display("%0t:          actual   kind %0d tx %02h data %04h err %0d last %0d",
                   $realtime, got.out_kind, got.tx_byte, got.read_data, got.crc_error,
                   got.last);
        end
      end
    end
  endtask

  // score results, follow the register, predict from accepted items
  always @(posedge clk) begin
    if (rst) begin
      crc_on = 1'b1;
      rd_addr_byte = 8'h00;
      rd_register = 8'h00;
      frame_q.delete();
      fail_count = 0;
    end else begin
      if (res_valid && !res_stall) begin
        check_result(res_item);
      end
      if (cfg_valid && cfg_ready) begin
        crc_on = cfg_data;
      end
      if (req_valid && !req_stall) begin
        predict_frames(req_item);
      end
    end
    open_results <= frame_q.size();
  end

endmodule

### tb/spi_register_frame_crc8_tb.sv
`timescale 1ns / 100ps

module spi_register_frame_crc8_tb;
  import srfc8_pkg::*;
  import srfc8_tb_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         hold_asks = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         fail_count;
  int         open_results;
  // read address byte and register the block should be holding
  logic [7:0] last_rd_addr = 8'h00;
  logic [7:0] last_rd_reg = 8'h00;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  spi_register_frame_crc8 i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  spi_register_frame_crc8_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_item     (req_item),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_item     (res_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      res_stall <= 1'b1;
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else begin
      res_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t pack_req(input logic [1:0] kind, input logic [6:0] addr,
                                        input logic [7:0] reg_no, input logic [7:0] lo,
                                        input logic [7:0] hi, input logic [7:0] rc);
    in_item_t it;
    it.req_type = kind;
    it.device_address = addr;
    it.register_index = reg_no;
    it.data_low = lo;
    it.data_high = hi;
    it.rx_crc = rc;
    return it;
  endfunction

  // read response for the last read request, crc right or one bit off
  function automatic in_item_t read_reply(input logic good);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] rc;
    lo = 8'($urandom);
    hi = 8'($urandom);
    rc = crc8_of4(last_rd_addr, last_rd_reg, lo, hi);
    if (!good) begin
      rc = rc ^ (8'h01 << $urandom_range(7));
    end
    return pack_req(REQ_RESP, 7'($urandom), 8'($urandom), lo, hi, rc);
  endfunction

  function automatic in_item_t any_req(input logic [1:0] kind);
    return pack_req(kind, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic offer(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= it;
    if (it.req_type == REQ_READ) begin
      last_rd_addr = {it.device_address, 1'b0} | READ_BIT;
      last_rd_reg = it.register_index;
    end
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (open_results != 0);
  endtask

  // crc_enable is only changed once the block has gone quiet
  task automatic set_crc_enable(input logic on);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= on;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly read request and response pairs, plus writes and stray items
  task automatic random_phase(input int count, input logic pressure);
    int   sent;
    int   pick;
    logic held;
    logic drained;
    sent = 0;
    held = 1'b0;
    drained = 1'b0;
    while (sent < count) begin
      if (pressure && !held && sent >= count / 4) begin
        hold_asks <= hold_asks + 1;
        held = 1'b1;
      end
      if (pressure && !drained && sent >= count / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        offer(any_req(REQ_READ));
        offer(read_reply($urandom_range(3) != 0));
        sent += 2;
      end else if (pick < 72) begin
        offer(any_req(REQ_WRITE));
        sent++;
      end else if (pick < 82) begin
        offer(read_reply($urandom_range(1) != 0));
        sent++;
      end else if (pick < 90) begin
        offer(any_req(REQ_RESP));
        sent++;
      end else if (pick < 95) begin
        offer(any_req(REQ_READ));
        sent++;
      end else begin
        offer(any_req(REQ_NONE));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, crc on: extremes, response with nothing stored, ignored fields
    set_crc_enable(1'b1);
    offer(pack_req(REQ_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    offer(pack_req(REQ_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer(read_reply(1'b1));
    offer(read_reply(1'b0));
    offer(pack_req(REQ_READ, 7'h7F, 8'hFF, 8'h5A, 8'hA5, 8'hAA));
    offer(read_reply(1'b1));
    offer(read_reply(1'b0));
    offer(pack_req(REQ_NONE, 7'h55, 8'h33, 8'h11, 8'h22, 8'h44));
    offer(read_reply(1'b1));
    offer(pack_req(REQ_WRITE, 7'h2A, 8'h81, 8'h7E, 8'h01, 8'hFF));
    offer(read_reply(1'b1));
    offer(pack_req(REQ_READ, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    offer(pack_req(REQ_RESP, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer(pack_req(REQ_RESP, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // directed, crc off: four-byte frames and no crc error
    set_crc_enable(1'b0);
    offer(pack_req(REQ_WRITE, 7'h01, 8'h80, 8'hC3, 8'h3C, 8'h00));
    offer(pack_req(REQ_READ, 7'h40, 8'h10, 8'hFF, 8'h00, 8'h12));
    offer(read_reply(1'b0));
    offer(pack_req(REQ_RESP, 7'h00, 8'h00, 8'h34, 8'h12, 8'h00));
    offer(pack_req(REQ_NONE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    set_crc_enable(1'b1);
    tx_idle_pct = 28;
    rx_idle_pct = 64;
    random_phase(70, 1'b0);

    set_crc_enable(1'b0);
    tx_idle_pct = 64;
    rx_idle_pct = 28;
    random_phase(65, 1'b0);

    set_crc_enable(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(65, 1'b1);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
